// ===== rtl/mean_goal_distance_cost_top_defines.svh =====
// Assertion macros shared by the mean goal distance cost RTL.
`ifndef MEAN_GOAL_DISTANCE_COST_TOP_DEFINES_SVH
`define MEAN_GOAL_DISTANCE_COST_TOP_DEFINES_SVH
// Property checked on every clock edge outside reset.
`define MGDC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define MGDC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/mgdc_pkg.sv =====
// Package with widths, types and constants of the mean goal distance cost block.
package mgdc_pkg;
  localparam int MaxPointsDefault = 64;
  localparam int CoordW = 32;
  localparam int DistW  = 33;
  localparam int SqW    = 66;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_GOAL_X = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GOAL_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_POWER  = 2'd3;
  localparam logic [31:0] WeightReset = 32'd327680;
  localparam logic [2:0]  PowerReset  = 3'd1;

  // Payload of one input point.
  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     last_point;
  } in_item_t;

  // Payload of one result.
  typedef struct packed {
    logic [31:0] cost;
    logic        saturated;
  } out_item_t;

  // Entry of the queue between front and back.
  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             valid_pt;
    logic             last_point;
  } dist_item_t;
endpackage

// ===== rtl/mgdc_if.sv =====
// Valid/ready channel interface used for input and result transfers.
interface mgdc_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mean_goal_distance_cost_top.sv =====
// Top level of the mean goal distance cost block.
// Each point passes through the front in order: the differences are formed, then the squares,
// then the bit-serial square root, one root digit a cycle, and then the distance is handed on;
// the front takes no new point until the last one has been handed on. The back accepts a point
// whenever it is accumulating. On the last point the back adds a long division, the weighting
// (high half, low half, then their sum) and the power steps before the cost is offered; the front
// keeps working on the next trajectory meanwhile, with a two-entry queue between the two.
module mean_goal_distance_cost_top import mgdc_pkg::*; #(
  parameter int MaxPoints = MaxPointsDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  mgdc_if.sink                in_ch,
  mgdc_if.source              out_ch
);
  logic signed [31:0] goal_x_r, goal_y_r;
  logic [31:0]        weight_r;
  logic [2:0]         power_r;
  logic               fq_valid, fq_ready, qb_valid, qb_ready;
  dist_item_t         fq_data, qb_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r <= '0;
      goal_y_r <= '0;
      weight_r <= WeightReset;
      power_r  <= PowerReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GOAL_X: goal_x_r <= cfg_wdata;
        CFG_GOAL_Y: goal_y_r <= cfg_wdata;
        CFG_WEIGHT: weight_r <= cfg_wdata;
        CFG_POWER:  power_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  mgdc_front u_front (
    .clk(clk), .rst_n(rst_n), .goal_x(goal_x_r), .goal_y(goal_y_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  mgdc_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  mgdc_back #(.MaxPoints(MaxPoints)) u_back (
    .clk(clk), .rst_n(rst_n), .cost_weight(weight_r), .cost_power(power_r),
    .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

// ===== rtl/mgdc_front.sv =====
// Front part: difference, squares and iterative square root for each point.
module mgdc_front import mgdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic signed [31:0]   goal_x,
  input  logic signed [31:0]   goal_y,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 q_valid,
  input  logic                 q_ready,
  output dist_item_t           q_data
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [32:0]      ax_r, ay_r;
  logic             last_r;
  logic [SqW-1:0]   sq_r;
  logic [DistW-1:0] root_r;
  logic [DistW+1:0] rem_r;
  logic [5:0]       step_r;
  logic signed [32:0] dx, dy;
  logic [65:0]      sx, sy;
  logic [DistW+1:0] rem_sh, trial;
  logic [1:0]       pair;

  // Exact signed differences and the squares of their magnitudes.
  assign dx = 33'(signed'(in_data.point_x)) - 33'(signed'(goal_x));
  assign dy = 33'(signed'(in_data.point_y)) - 33'(signed'(goal_y));
  assign sx = 66'(ax_r) * 66'(ax_r);
  assign sy = 66'(ay_r) * 66'(ay_r);

  // One root digit per cycle, most significant pair first.
  assign pair   = sq_r[SqW-1:SqW-2];
  assign rem_sh = {rem_r[DistW-1:0], pair};
  assign trial  = {root_r, 2'b01};

  assign in_ready = (state_r == ST_IDLE);
  assign q_valid  = (state_r == ST_OUT);
  assign q_data   = '{distance: root_r, valid_pt: 1'b1, last_point: last_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_ROOT;
      ST_ROOT: if (step_r == 6'd32) state_nxt = ST_OUT;
      ST_OUT:  if (q_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ax_r   <= dx[32] ? 33'(-dx) : 33'(dx);
        ay_r   <= dy[32] ? 33'(-dy) : 33'(dy);
        last_r <= in_data.last_point;
      end
      ST_SQ: begin
        sq_r   <= sx + sy;
        root_r <= '0;
        rem_r  <= '0;
        step_r <= '0;
      end
      ST_ROOT: begin
        sq_r   <= {sq_r[SqW-3:0], 2'b00};
        step_r <= step_r + 6'd1;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[DistW-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[DistW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/mgdc_queue.sv =====
// Two-entry queue of distances between front and back.
module mgdc_queue import mgdc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  dist_item_t wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output dist_item_t rd_data
);
`include "mean_goal_distance_cost_top_defines.svh"
  dist_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_fire, rd_fire;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_fire) wp_r <= ~wp_r;
      if (rd_fire) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_fire) - 2'(rd_fire);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (wr_fire) mem_r[wp_r] <= wr_data;
  end

  `MGDC_ASSERT(a_q_cnt, clk, rst_n, cnt_r != 2'd3, "queue count out of range")
  `MGDC_ASSERT(a_q_full, clk, rst_n, (cnt_r == 2'd2) |-> (wp_r == rp_r), "full queue pointer mismatch")
  `MGDC_ASSERT(a_q_empty, clk, rst_n, (cnt_r == 2'd0) |-> (wp_r == rp_r), "empty queue pointer mismatch")
endmodule

// ===== rtl/mgdc_back.sv =====
// Back part: accumulation, mean by long division, weighting and power.
module mgdc_back import mgdc_pkg::*; #(
  parameter int MaxPoints = MaxPointsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] cost_weight,
  input  logic [2:0]  cost_power,
  input  logic        q_valid,
  output logic        q_ready,
  input  dist_item_t  q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);
`include "mean_goal_distance_cost_top_defines.svh"
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int SumW = DistW + CntW;
  localparam int DivStW = $clog2(SumW + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxPoints);

  localparam logic [2:0] ST_ACC  = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_WHI  = 3'd2;
  localparam logic [2:0] ST_WLO  = 3'd3;
  localparam logic [2:0] ST_WSUM = 3'd4;
  localparam logic [2:0] ST_POW  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]        state_r;
  logic [SumW-1:0]   sum_r;
  logic [CntW-1:0]   cnt_r;
  logic              ovf_r;
  logic [SumW-1:0]   quo_r;
  logic [CntW:0]     rem_r;
  logic [DivStW-1:0] dstep_r;
  logic [SumW+15:0]  whi_r;
  logic [SumW+15:0]  wlo_r;
  logic [SumW+16:0]  w_r;
  logic [2:0]        pstep_r;
  logic [32:0]       acc_r;
  logic              sat_r;
  logic [CntW:0]     rem_sh;
  logic [63:0]       prod;
  logic              take;

  assign q_ready   = (state_r == ST_ACC);
  assign take      = q_valid && q_ready;
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = '{cost: acc_r[31:0], saturated: sat_r | ovf_r};

  // Restoring division, one quotient bit a cycle.
  assign rem_sh = {rem_r[CntW-1:0], quo_r[SumW-1]};
  // Full Q32.32 product of two Q16.16 values in one power step, truncated when taken.
  assign prod = 64'(acc_r[31:0]) * 64'(w_r[31:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      sum_r   <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_ACC: if (take) begin
          if (cnt_r == CntMax) begin
            ovf_r <= 1'b1;
            quo_r <= sum_r;
          end else begin
            sum_r <= sum_r + SumW'(q_data.distance);
            cnt_r <= cnt_r + CntW'(1);
            quo_r <= sum_r + SumW'(q_data.distance);
          end
          rem_r   <= '0;
          dstep_r <= '0;
          if (q_data.last_point) state_r <= ST_DIV;
        end
        ST_DIV: begin
          dstep_r <= dstep_r + DivStW'(1);
          if (rem_sh >= (CntW+1)'(cnt_r)) begin
            rem_r <= rem_sh - (CntW+1)'(cnt_r);
            quo_r <= {quo_r[SumW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[SumW-2:0], 1'b0};
          end
          if (dstep_r == DivStW'(SumW - 1)) state_r <= ST_WHI;
        end
        ST_WHI: begin
          whi_r   <= (SumW+16)'(quo_r) * (SumW+16)'(cost_weight[31:16]);
          state_r <= ST_WLO;
        end
        ST_WLO: begin
          wlo_r   <= (SumW+16)'(quo_r) * (SumW+16)'(cost_weight[15:0]);
          state_r <= ST_WSUM;
        end
        ST_WSUM: begin
          w_r     <= (SumW+17)'(whi_r) + (SumW+17)'(wlo_r[SumW+15:16]);
          acc_r   <= 33'd65536;
          sat_r   <= 1'b0;
          pstep_r <= '0;
          state_r <= ST_POW;
        end
        ST_POW: begin
          if (pstep_r == cost_power || sat_r) begin
            if (sat_r) acc_r <= 33'h0FFFFFFFF;
            state_r <= ST_OUT;
          end else begin
            pstep_r <= pstep_r + 3'd1;
            if (w_r[SumW+16:32] != '0) begin
              sat_r <= 1'b1;
            end else if (prod[63:48] != 16'd0) begin
              sat_r <= 1'b1;
            end else begin
              acc_r <= {1'b0, prod[47:16]};
            end
          end
        end
        ST_OUT: if (out_ready) begin
          sum_r   <= '0;
          cnt_r   <= '0;
          ovf_r   <= 1'b0;
          state_r <= ST_ACC;
        end
        default: state_r <= ST_ACC;
      endcase
    end
  end

  `MGDC_ASSERT(a_cnt_max, clk, rst_n, cnt_r <= CntMax, "point count beyond maximum")
  `MGDC_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped")
  `MGDC_ASSERT(a_sat_cost, clk, rst_n, (out_valid && sat_r) |-> (acc_r[31:0] == 32'hFFFFFFFF), "saturated cost not at maximum")
endmodule

// ===== test/mean_goal_distance_cost_checker.sv =====
// Checker that predicts the trajectory costs and compares the result transfers.
module mean_goal_distance_cost_checker import mgdc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  output int                  fail_count,
  output int                  pending_costs
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPts = MaxPointsDefault;

  // Copy of the configuration and of the trajectory state.
  logic signed [31:0] goal_x_q, goal_y_q;
  logic [31:0]        weight_q;
  logic [2:0]         power_q;
  logic [39:0]        dist_sum_q;
  int                 point_cnt_q;
  logic               overflow_q;
  out_item_t          expected_costs[$];

  assign pending_costs = expected_costs.size();

  // Floor square root of a 66-bit sum of squares, one digit at a time.
  function automatic logic [32:0] floor_sqrt(input logic [65:0] val);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [32:0] root;
    rem = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | val[2*i +: 2];
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[31:0], 1'b1};
      end else begin
        root = {root[31:0], 1'b0};
      end
    end
    return root;
  endfunction

  // Distance of one point to the goal, unsigned Q16.16.
  function automatic logic [32:0] goal_distance(input logic signed [31:0] px,
                                                input logic signed [31:0] py);
    logic signed [33:0] dx, dy;
    logic [32:0] ax, ay;
    logic [65:0] sq;
    dx = 34'(px) - 34'(goal_x_q);
    dy = 34'(py) - 34'(goal_y_q);
    ax = dx < 0 ? 33'(-dx) : 33'(dx);
    ay = dy < 0 ? 33'(-dy) : 33'(dy);
    sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
    return floor_sqrt(sq);
  endfunction

  // Weighted mean raised to the configured power.
  function automatic out_item_t trajectory_cost();
    logic [39:0] mean;
    logic [79:0] weighted;
    logic [95:0] acc;
    logic        sat;
    out_item_t   res;
    mean = point_cnt_q != 0 ? dist_sum_q / 40'(point_cnt_q) : '0;
    weighted = 80'(mean) * 80'(weight_q[31:16]) + ((80'(mean) * 80'(weight_q[15:0])) >> 16);
    sat = 1'b0;
    acc = 96'd65536;
    for (int k = 0; k < int'(power_q) && !sat; k++) begin
      if (weighted > 80'hFFFF_FFFF) begin
        sat = 1'b1;
      end else begin
        acc = (acc * 96'(weighted)) >> 16;
        if (acc > 96'hFFFF_FFFF) sat = 1'b1;
      end
    end
    res.cost = sat ? 32'hFFFF_FFFF : acc[31:0];
    res.saturated = sat | overflow_q;
    return res;
  endfunction

  // Report one mismatch and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Track configuration writes and input transfers, compare result transfers.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      goal_x_q <= '0;
      goal_y_q <= '0;
      weight_q <= WeightReset;
      power_q <= PowerReset;
      dist_sum_q = '0;
      point_cnt_q = 0;
      overflow_q = 1'b0;
      expected_costs.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GOAL_X: goal_x_q <= cfg_wdata;
          CFG_GOAL_Y: goal_y_q <= cfg_wdata;
          CFG_WEIGHT: weight_q <= cfg_wdata;
          CFG_POWER:  power_q <= cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (point_cnt_q >= MaxPts) begin
          overflow_q = 1'b1;
        end else begin
          dist_sum_q = dist_sum_q + 40'(goal_distance(in_data.point_x, in_data.point_y));
          point_cnt_q++;
        end
        if (in_data.last_point) begin
          expected_costs.push_back(trajectory_cost());
          dist_sum_q = '0;
          point_cnt_q = 0;
          overflow_q = 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_costs.size() == 0) begin
          report_mismatch("unexpected cost", out_data.cost, '0);
        end else begin
          want = expected_costs.pop_front();
          if (out_data.cost !== want.cost) report_mismatch("cost", out_data.cost, want.cost);
          if (out_data.saturated !== want.saturated)
            report_mismatch("saturated", 32'(out_data.saturated), 32'(want.saturated));
        end
      end
    end
  end
endmodule

// ===== test/mean_goal_distance_cost_top_test.sv =====
// Top of the mean goal distance cost testbench: stimulus, configuration and verdict.
module mean_goal_distance_cost_top_test import mgdc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2_000_000;
  localparam int TailCycles = 200;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CFG_GOAL_X;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  int                  fail_count;
  int                  pending_costs;
  int                  cycle_count = 0;
  logic                long_hold = 1'b0;

  mgdc_if #(.payload_t(in_item_t))  point_ch ();
  mgdc_if #(.payload_t(out_item_t)) cost_ch ();

  mean_goal_distance_cost_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(point_ch.sink), .out_ch(cost_ch.source)
  );

  mean_goal_distance_cost_checker checker_i (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(point_ch.valid), .in_ready(point_ch.ready),
    .in_data(point_ch.data), .out_valid(cost_ch.valid), .out_ready(cost_ch.ready),
    .out_data(cost_ch.data), .fail_count(fail_count), .pending_costs(pending_costs)
  );

  initial begin
    point_ch.valid = 1'b0;
    point_ch.data = '0;
    cost_ch.ready = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("mean_goal_distance_cost_top_test NOT OK");
      $finish;
    end
  end

  // Receiver: random stall before each transfer, long hold-off on request.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        cost_ch.ready <= 1'b0;
        for (int i = 0; i < 3000; i++) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        cost_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cost_ch.ready <= 1'b1;
      @(posedge clk iff cost_ch.valid);
    end
  end

  // Configuration write while the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stop offering points, wait for every outstanding cost, then let the back end drain.
  task automatic drain_costs();
    point_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_costs != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  // Offer one point after a random gap (none when no_gap is set), hold it until transferred.
  task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                            input logic last, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
    if (gap != 0) begin
      point_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_ch.valid <= 1'b1;
    point_ch.data <= '{point_x: px, point_y: py, last_point: last};
    @(posedge clk iff point_ch.ready);
  endtask

  // Random coordinate: half the time within 10.0 of zero, otherwise anywhere or at an extreme.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  // One trajectory of the given length with random points.
  task automatic send_trajectory(input int len);
    for (int i = 0; i < len; i++)
      send_point(rand_coord(), rand_coord(), i == len - 1, 1'b0);
  endtask

  initial begin
    int sent;
    int len;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset configuration: single points at the extremes and near zero, then two points.
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    send_point(32'h0003_0000, 32'h0004_0000, 1'b1, 1'b0);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0);
    send_point(32'h0001_0000, 32'hFFFF_0000, 1'b1, 1'b0);
    drain_costs();

    // Extreme goal and weight, power zero, then maximum power.
    write_reg(CFG_GOAL_X, 32'h8000_0000);
    write_reg(CFG_GOAL_Y, 32'h7FFF_FFFF);
    write_reg(CFG_WEIGHT, 32'hFFFF_FFFF);
    write_reg(CFG_POWER, 3'd0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
    drain_costs();
    write_reg(CFG_POWER, 3'd7);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
    drain_costs();

    // Too many points: a trajectory longer than the point limit and one at the limit, then a zero weight.
    write_reg(CFG_GOAL_X, 32'h0000_0000);
    write_reg(CFG_GOAL_Y, 32'h0000_0000);
    write_reg(CFG_POWER, 3'd2);
    write_reg(CFG_WEIGHT, 32'h0001_0000);
    send_trajectory(MaxPointsDefault + 3);
    send_trajectory(MaxPointsDefault);
    drain_costs();
    write_reg(CFG_WEIGHT, 32'h0000_0000);
    send_trajectory(3);
    drain_costs();

    // Random part: phases of random configuration with random trajectories.
    sent = 0;
    while (sent < 280) begin
      write_reg(CFG_GOAL_X, rand_coord());
      write_reg(CFG_GOAL_Y, rand_coord());
      write_reg(CFG_WEIGHT, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 4 << 16));
      write_reg(CFG_POWER, $urandom_range(0, 7));
      for (int t = 0; t < 12; t++) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        send_trajectory(len);
        sent += len;
      end
      drain_costs();
    end

    // Back-pressure: the receiver holds off while single-point trajectories keep coming.
    long_hold = 1'b1;
    for (int i = 0; i < 20; i++) send_point(rand_coord(), rand_coord(), 1'b1, 1'b1);
    drain_costs();

    if (fail_count == 0) begin
      $display("mean_goal_distance_cost_top_test OK");
    end else begin
      $display("mean_goal_distance_cost_top_test NOT OK");
    end
    $finish;
  end
endmodule
